@@ rtl/ecdt_pkg.sv @@
// ----------------------------------------------------------------------------
// ecdt_pkg
// Constants, types and small tables for the epoch seconds to civil date and
// time pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ecdt_pkg;

    localparam int unsigned IN_W = 39;

    // Input window, expressed on the biased scale (input + 2^38).
    localparam logic [IN_W-1:0] SIGN_BIT = 39'h40_0000_0000;
    localparam logic [IN_W-1:0] BIAS_LO  = 39'd212710687744;
    localparam logic [IN_W-1:0] BIAS_HI  = 39'd528280207743;

    // Seconds per day is 2^7 * 675: the low seven bits pass straight into
    // the second of day and the rest is divided by 675.
    localparam int unsigned DAY_SHIFT  = 7;
    localparam logic [31:0] DAY_RECIP  = 32'd3257812230;  // floor(2^41 / 675)
    localparam int unsigned DAY_RSHIFT = 41;
    localparam logic [9:0]  DAY_DIV    = 10'd675;

    // Shift from days since 0000-01-01 to days since March 1 of year -400.
    localparam logic [22:0] MARCH_OFS  = 23'd146037;

    localparam logic [17:0] ERA_DAYS   = 18'd146097;
    localparam logic [5:0]  ERA_RECIP  = 6'd57;           // floor(2^23 / 146097)
    localparam logic [17:0] ERA_LAST   = 18'd146096;

    localparam logic [10:0] QUAD_DAYS  = 11'd1460;
    localparam logic [7:0]  QUAD_RECIP = 8'd179;          // floor(2^18 / 1460)
    localparam logic [17:0] CENT_DAYS  = 18'd36524;

    localparam logic [8:0]  YEAR_DAYS  = 9'd365;
    localparam logic [9:0]  YEAR_RECIP = 10'd718;         // floor(2^18 / 365)

    localparam logic [7:0]  MP_DAYS    = 8'd153;
    localparam logic [3:0]  MP_RECIP   = 4'd13;           // floor(2^11 / 153)

    localparam logic [5:0]  SIXTY      = 6'd60;
    localparam logic [11:0] MIN_RECIP  = 12'd2184;        // floor(2^17 / 60)
    localparam logic [5:0]  HOUR_RECIP = 6'd34;           // floor(2^11 / 60)

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_tod;

    // Day of the March-based year on which each month starts.
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] v;
        case (mp)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/epoch_seconds_to_civil_datetime_core.sv @@
// ----------------------------------------------------------------------------
// epoch_seconds_to_civil_datetime_core
// Converts signed seconds since 1970-01-01 00:00:00 into proleptic Gregorian
// year, month, day, hour, minute and second.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (i_valid, o_stall, i_epoch_seconds) takes one item per
//   cycle while the output is not stalled. The output channel (o_valid,
//   i_stall, o_year .. o_out_of_range) gives exactly one result item per
//   input item, in order. There are 17 register stages, the first loaded at
//   the accepting edge. Throughput is one item per cycle while the output is
//   not stalled; every division by a constant is a reciprocal multiply in one
//   stage, a residual in the next and a single correction after that, which
//   sets the stage count.
//   Inputs outside 0000-01-01 00:00:00 to 9999-12-31 23:59:59 set
//   o_out_of_range and zero every date and time field.
//   Reset clears all valid bits; the pipeline comes up empty. While the
//   receiver stalls a held result, the whole pipeline freezes and o_stall is
//   raised to the sender; nothing is dropped or repeated. Bubbles ahead of a
//   stalled result are not squeezed out.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_seconds_to_civil_datetime_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [38:0] i_epoch_seconds,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [13:0]             o_year,
    output logic [3:0]              o_month,
    output logic [4:0]              o_day,
    output logic [4:0]              o_hour,
    output logic [5:0]              o_minute,
    output logic [5:0]              o_second,
    output logic                    o_out_of_range
);

    localparam int unsigned NUM_STAGES = 17;

    logic advance;

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-2:0] r_oor;

    // Stage registers.
    logic [31:0] r1_u;
    logic [6:0]  r1_lo7;
    logic [22:0] r2_qe;
    logic [31:0] r2_u;
    logic [6:0]  r2_lo7;
    logic [22:0] r3_qe;
    logic [10:0] r3_rem;
    logic [6:0]  r3_lo7;
    logic [22:0] r4_z;
    logic [16:0] r4_sod;
    logic [22:0] r5_z;
    logic [5:0]  r5_era_e;
    logic [16:0] r5_sod;
    logic [10:0] r5_mt_e;
    logic [18:0] r6_doe_r;
    logic [5:0]  r6_era_e;
    logic [6:0]  r6_sr;
    logic [10:0] r6_mt_e;
    logic [5:0]  r7_era;
    logic [17:0] r7_doe;
    logic [10:0] r7_mtot;
    logic [5:0]  r7_sec;
    logic [5:0]  r8_era;
    logic [17:0] r8_doe;
    logic [7:0]  r8_c1460_e;
    logic [2:0]  r8_c36524;
    logic        r8_c146096;
    logic [10:0] r8_mtot;
    logic [5:0]  r8_hour_e;
    logic [5:0]  r8_sec;
    logic [5:0]  r9_era;
    logic [17:0] r9_doe;
    logic [7:0]  r9_c1460_e;
    logic [11:0] r9_r1460;
    logic [2:0]  r9_c36524;
    logic        r9_c146096;
    logic [5:0]  r9_hour_e;
    logic [6:0]  r9_mr;
    logic [5:0]  r9_sec;
    logic [5:0]  r10_era;
    logic [17:0] r10_doe;
    logic [17:0] r10_n;
    ecdt_pkg::t_tod r10_tod;
    logic [5:0]  r11_era;
    logic [17:0] r11_doe;
    logic [17:0] r11_n;
    logic [9:0]  r11_ye;
    ecdt_pkg::t_tod r11_tod;
    logic [5:0]  r12_era;
    logic [17:0] r12_doe;
    logic [9:0]  r12_ye;
    logic [9:0]  r12_yr;
    ecdt_pkg::t_tod r12_tod;
    logic [5:0]  r13_era;
    logic [17:0] r13_doe;
    logic [8:0]  r13_yoe;
    ecdt_pkg::t_tod r13_tod;
    logic [5:0]  r14_era;
    logic [8:0]  r14_yoe;
    logic [8:0]  r14_doy;
    ecdt_pkg::t_tod r14_tod;
    logic [5:0]  r15_era;
    logic [8:0]  r15_yoe;
    logic [8:0]  r15_doy;
    logic [11:0] r15_x;
    logic [4:0]  r15_mp_e;
    ecdt_pkg::t_tod r15_tod;
    logic [5:0]  r16_era;
    logic [8:0]  r16_yoe;
    logic [8:0]  r16_doy;
    logic [4:0]  r16_mp_e;
    logic [8:0]  r16_mr2;
    ecdt_pkg::t_tod r16_tod;
    logic [13:0] r_year;
    logic [3:0]  r_month;
    logic [4:0]  r_day;
    ecdt_pkg::t_tod r_tod;
    logic        r_oor_out;

    // Next values and combinational helpers.
    logic [38:0] s1_biased;
    logic [38:0] n1_t;
    logic        n1_oor;
    logic [63:0] n2_prod;
    logic [32:0] s3_p;
    logic [31:0] s3_diff;
    logic        s4_ge;
    logic [22:0] s4_days;
    logic [9:0]  s4_rr;
    logic [28:0] s5_pz;
    logic [28:0] s5_ps;
    logic [23:0] s6_pe;
    logic [23:0] s6_de;
    logic [16:0] s6_pm;
    logic [16:0] s6_dm;
    logic        s7_ge_e;
    logic        s7_ge_m;
    logic [18:0] s7_doe;
    logic [6:0]  s7_sec;
    logic [25:0] s8_pq;
    logic [16:0] s8_ph;
    logic [18:0] s9_pq;
    logic [18:0] s9_dq;
    logic [11:0] s9_ph;
    logic [11:0] s9_dh;
    logic        s10_ge_q;
    logic        s10_ge_h;
    logic [7:0]  s10_c1460;
    logic [6:0]  s10_min;
    logic [27:0] s11_py;
    logic [18:0] s12_py;
    logic [17:0] s12_dy;
    logic [9:0]  s13_yoe;
    logic [1:0]  s14_c100;
    logic [17:0] s14_base;
    logic [17:0] s14_d;
    logic [11:0] s15_x;
    logic [15:0] s15_pm;
    logic [12:0] s16_pm;
    logic [12:0] s16_d;
    logic [4:0]  s17_mp5;
    logic [3:0]  s17_mp;
    logic [8:0]  s17_day9;
    logic [3:0]  s17_month;
    logic [14:0] s17_year;

    assign advance = !(r_vld[NUM_STAGES-1] && i_stall);
    assign o_stall = r_vld[NUM_STAGES-1] && i_stall;

    always_comb begin
        // Stage 1: range check and shift to seconds since year 0.
        s1_biased = $unsigned(i_epoch_seconds) ^ ecdt_pkg::SIGN_BIT;
        n1_oor    = (s1_biased < ecdt_pkg::BIAS_LO) || (s1_biased > ecdt_pkg::BIAS_HI);
        n1_t      = s1_biased - ecdt_pkg::BIAS_LO;

        // Stage 2: day estimate, which is the true quotient or one short.
        n2_prod = 64'(r1_u) * 64'(ecdt_pkg::DAY_RECIP);

        // Stage 3: residual of the day estimate.
        s3_p    = 33'(r2_qe) * 33'(ecdt_pkg::DAY_DIV);
        s3_diff = r2_u - s3_p[31:0];

        // Stage 4: correct the day count and move onto the March-based era.
        s4_ge   = r3_rem >= 11'(ecdt_pkg::DAY_DIV);
        s4_days = r3_qe + 23'(s4_ge);
        s4_rr   = s4_ge ? 10'(r3_rem - 11'(ecdt_pkg::DAY_DIV)) : r3_rem[9:0];

        // Stage 5: era and minute-of-day estimates.
        s5_pz = 29'(r4_z) * 29'(ecdt_pkg::ERA_RECIP);
        s5_ps = 29'(r4_sod) * 29'(ecdt_pkg::MIN_RECIP);

        // Stage 6: residuals.
        s6_pe = 24'(r5_era_e) * 24'(ecdt_pkg::ERA_DAYS);
        s6_de = 24'(r5_z) - s6_pe;
        s6_pm = 17'(r5_mt_e) * 17'(ecdt_pkg::SIXTY);
        s6_dm = r5_sod - s6_pm;

        // Stage 7: corrections.
        s7_ge_e = r6_doe_r >= 19'(ecdt_pkg::ERA_DAYS);
        s7_doe  = s7_ge_e ? (r6_doe_r - 19'(ecdt_pkg::ERA_DAYS)) : r6_doe_r;
        s7_ge_m = r6_sr >= 7'(ecdt_pkg::SIXTY);
        s7_sec  = s7_ge_m ? (r6_sr - 7'(ecdt_pkg::SIXTY)) : r6_sr;

        // Stage 8: four-year and hour estimates.
        s8_pq = 26'(r7_doe) * 26'(ecdt_pkg::QUAD_RECIP);
        s8_ph = 17'(r7_mtot) * 17'(ecdt_pkg::HOUR_RECIP);

        // Stage 9: residuals.
        s9_pq = 19'(r8_c1460_e) * 19'(ecdt_pkg::QUAD_DAYS);
        s9_dq = 19'(r8_doe) - s9_pq;
        s9_ph = 12'(r8_hour_e) * 12'(ecdt_pkg::SIXTY);
        s9_dh = 12'(r8_mtot) - s9_ph;

        // Stage 10: corrections and the leap-day-free day count.
        s10_ge_q  = r9_r1460 >= 12'(ecdt_pkg::QUAD_DAYS);
        s10_c1460 = r9_c1460_e + 8'(s10_ge_q);
        s10_ge_h  = r9_mr >= 7'(ecdt_pkg::SIXTY);
        s10_min   = s10_ge_h ? (r9_mr - 7'(ecdt_pkg::SIXTY)) : r9_mr;

        // Stage 11: year-of-era estimate.
        s11_py = 28'(r10_n) * 28'(ecdt_pkg::YEAR_RECIP);

        // Stage 12: residual.
        s12_py = 19'(r11_ye) * 19'(ecdt_pkg::YEAR_DAYS);
        s12_dy = r11_n - s12_py[17:0];

        // Stage 13: correction.
        s13_yoe = r12_ye + 10'(r12_yr >= 10'(ecdt_pkg::YEAR_DAYS));

        // Stage 14: day of the March-based year.
        s14_c100 = 2'(r13_yoe >= 9'd100) + 2'(r13_yoe >= 9'd200) + 2'(r13_yoe >= 9'd300);
        s14_base = 18'(r13_yoe) * 18'(ecdt_pkg::YEAR_DAYS) + 18'(r13_yoe[8:2])
                   - 18'(s14_c100);
        s14_d    = r13_doe - s14_base;

        // Stage 15: month estimate.
        s15_x  = 12'(r14_doy) * 12'd5 + 12'd2;
        s15_pm = 16'(s15_x) * 16'(ecdt_pkg::MP_RECIP);

        // Stage 16: residual.
        s16_pm = 13'(r15_mp_e) * 13'(ecdt_pkg::MP_DAYS);
        s16_d  = 13'(r15_x) - s16_pm;

        // Stage 17: month, day and year.
        s17_mp5   = r16_mp_e + 5'(r16_mr2 >= 9'(ecdt_pkg::MP_DAYS));
        s17_mp    = s17_mp5[3:0];
        s17_day9  = r16_doy - ecdt_pkg::month_start(s17_mp) + 9'd1;
        s17_month = (s17_mp < 4'd10) ? (s17_mp + 4'd3) : (s17_mp - 4'd9);
        s17_year  = 15'(r16_yoe) + 15'(r16_era) * 15'd400
                    + 15'(s17_month <= 4'd2) - 15'd400;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (advance) begin
            r_vld <= {r_vld[NUM_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_oor <= {r_oor[NUM_STAGES-3:0], n1_oor};

            r1_u   <= n1_t[38:ecdt_pkg::DAY_SHIFT];
            r1_lo7 <= n1_t[ecdt_pkg::DAY_SHIFT-1:0];

            r2_qe  <= n2_prod[63:ecdt_pkg::DAY_RSHIFT];
            r2_u   <= r1_u;
            r2_lo7 <= r1_lo7;

            r3_qe  <= r2_qe;
            r3_rem <= s3_diff[10:0];
            r3_lo7 <= r2_lo7;

            r4_z   <= s4_days + ecdt_pkg::MARCH_OFS;
            r4_sod <= {s4_rr, r3_lo7};

            r5_z     <= r4_z;
            r5_era_e <= s5_pz[28:23];
            r5_sod   <= r4_sod;
            r5_mt_e  <= s5_ps[27:17];

            r6_doe_r <= s6_de[18:0];
            r6_era_e <= r5_era_e;
            r6_sr    <= s6_dm[6:0];
            r6_mt_e  <= r5_mt_e;

            r7_era  <= r6_era_e + 6'(s7_ge_e);
            r7_doe  <= s7_doe[17:0];
            r7_mtot <= r6_mt_e + 11'(s7_ge_m);
            r7_sec  <= s7_sec[5:0];

            r8_era     <= r7_era;
            r8_doe     <= r7_doe;
            r8_c1460_e <= s8_pq[25:18];
            r8_c36524  <= 3'(r7_doe >= ecdt_pkg::CENT_DAYS)
                          + 3'(r7_doe >= 18'd73048)
                          + 3'(r7_doe >= 18'd109572)
                          + 3'(r7_doe >= ecdt_pkg::ERA_LAST);
            r8_c146096 <= r7_doe == ecdt_pkg::ERA_LAST;
            r8_mtot    <= r7_mtot;
            r8_hour_e  <= s8_ph[16:11];
            r8_sec     <= r7_sec;

            r9_era     <= r8_era;
            r9_doe     <= r8_doe;
            r9_c1460_e <= r8_c1460_e;
            r9_r1460   <= s9_dq[11:0];
            r9_c36524  <= r8_c36524;
            r9_c146096 <= r8_c146096;
            r9_hour_e  <= r8_hour_e;
            r9_mr      <= s9_dh[6:0];
            r9_sec     <= r8_sec;

            r10_era        <= r9_era;
            r10_doe        <= r9_doe;
            r10_n          <= r9_doe - 18'(s10_c1460) + 18'(r9_c36524) - 18'(r9_c146096);
            r10_tod.hour   <= 5'(r9_hour_e + 6'(s10_ge_h));
            r10_tod.minute <= s10_min[5:0];
            r10_tod.second <= r9_sec;

            r11_era <= r10_era;
            r11_doe <= r10_doe;
            r11_n   <= r10_n;
            r11_ye  <= s11_py[27:18];
            r11_tod <= r10_tod;

            r12_era <= r11_era;
            r12_doe <= r11_doe;
            r12_ye  <= r11_ye;
            r12_yr  <= s12_dy[9:0];
            r12_tod <= r11_tod;

            r13_era <= r12_era;
            r13_doe <= r12_doe;
            r13_yoe <= s13_yoe[8:0];
            r13_tod <= r12_tod;

            r14_era <= r13_era;
            r14_yoe <= r13_yoe;
            r14_doy <= s14_d[8:0];
            r14_tod <= r13_tod;

            r15_era  <= r14_era;
            r15_yoe  <= r14_yoe;
            r15_doy  <= r14_doy;
            r15_x    <= s15_x;
            r15_mp_e <= s15_pm[15:11];
            r15_tod  <= r14_tod;

            r16_era  <= r15_era;
            r16_yoe  <= r15_yoe;
            r16_doy  <= r15_doy;
            r16_mp_e <= r15_mp_e;
            r16_mr2  <= s16_d[8:0];
            r16_tod  <= r15_tod;

            // An out-of-range item reports zero in every field.
            r_oor_out <= r_oor[NUM_STAGES-2];
            if (r_oor[NUM_STAGES-2]) begin
                r_year  <= '0;
                r_month <= '0;
                r_day   <= '0;
                r_tod   <= '0;
            end else begin
                r_year  <= s17_year[13:0];
                r_month <= s17_month;
                r_day   <= s17_day9[4:0];
                r_tod   <= r16_tod;
            end
        end
    end

    assign o_valid        = r_vld[NUM_STAGES-1];
    assign o_year         = r_year;
    assign o_month        = r_month;
    assign o_day          = r_day;
    assign o_hour         = r_tod.hour;
    assign o_minute       = r_tod.minute;
    assign o_second       = r_tod.second;
    assign o_out_of_range = r_oor_out;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled while the output stage is empty");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted item did not enter the first stage");

    a_date_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out_of_range) |->
        (o_month >= 4'd1 && o_month <= 4'd12 && o_day >= 5'd1 && o_day <= 5'd31
         && o_year <= 14'd9999))
        else $error("date field out of its range");

    a_time_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hour <= 5'd23 && o_minute <= 6'd59 && o_second <= 6'd59))
        else $error("time field out of its range");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_of_range) |->
        (o_year == '0 && o_month == '0 && o_day == '0 && o_hour == '0
         && o_minute == '0 && o_second == '0))
        else $error("out-of-range item carries nonzero fields");

endmodule

`default_nettype wire
